// ===== sv/rpr_pkg.sv =====
// Shared types, widths, stage map and constant tables for the radial point remapper.
// Used by radial_point_remap_top and tb. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rpr_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int CW    = 32;   // coordinate width
  localparam int MAGW  = 33;   // |point - origin|
  localparam int SQW   = 66;   // one square
  localparam int SUMW  = 72;   // sqrt remainder width
  localparam int LENW  = 35;   // length
  localparam int MW    = 31;   // log2 mantissa, Q1.30
  localparam int FRW   = 16;   // log2 fraction bits
  localparam int EXW   = 16;   // exponent register
  localparam int YW    = 28;   // exponent * log2, Q.16
  localparam int YIW   = 12;   // integer part of y
  localparam int SHW   = 13;   // shift amount y_int - 30
  localparam int ACCW  = 32;   // exp2 accumulator
  localparam int BASEW = 64;
  localparam int PPW   = 65;   // partial product
  localparam int NUMW  = 96;
  localparam int XW    = 164;  // shifted numerator
  localparam int QW    = 34;   // quotient bits kept
  localparam int REMW  = 69;   // LENW + QW
  localparam int OVW   = 36;   // origin +/- quotient

  // Shift window: beyond these the quotient saturates or is zero.
  localparam int SH_MAX = 68;
  localparam int SH_MIN = -96;

  // pipeline stage map
  localparam int ST_SQR  = 1;
  localparam int ST_SUM  = 2;
  localparam int ST_LEN  = ST_SUM + LENW;      // 37
  localparam int ST_NORM = ST_LEN + 1;         // 38
  localparam int ST_Y    = ST_NORM + FRW + 1;  // 55
  localparam int ST_BASE = ST_Y + FRW + 1;     // 72
  localparam int ST_PART = ST_BASE + 1;
  localparam int ST_NUM  = ST_PART + 1;
  localparam int ST_SHF  = ST_NUM + 1;
  localparam int ST_SAT  = ST_SHF + 1;         // 76
  localparam int ST_DEND = ST_SAT + QW;        // 110
  localparam int ST_OUT  = ST_DEND + 1;        // 111
  localparam int NST     = ST_OUT + 1;

  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] CFG_EXPONENT = 3'd3;
  localparam logic [2:0] CFG_SCALE    = 3'd4;
  localparam logic [2:0] CFG_CUTOFF   = 3'd5;

  typedef struct packed {
    logic [2:0][MAGW-1:0] mag;
    logic [2:0]           neg;
  } side_t;

  // round(2^30 * 2^(2^-k)), k = 1 first
  function automatic logic [MW-1:0] exp2_coef(input logic [3:0] k);
    logic [MW-1:0] c;
    case (k)
      4'd0:    c = 31'd1518500250;
      4'd1:    c = 31'd1276901417;
      4'd2:    c = 31'd1170923762;
      4'd3:    c = 31'd1121280436;
      4'd4:    c = 31'd1097253708;
      4'd5:    c = 31'd1085434106;
      4'd6:    c = 31'd1079572136;
      4'd7:    c = 31'd1076653033;
      4'd8:    c = 31'd1075196443;
      4'd9:    c = 31'd1074468888;
      4'd10:   c = 31'd1074105294;
      4'd11:   c = 31'd1073923544;
      4'd12:   c = 31'd1073832680;
      4'd13:   c = 31'd1073787251;
      4'd14:   c = 31'd1073764537;
      4'd15:   c = 31'd1073753181;
      default: c = 31'd1073741824;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/radial_point_remap_top.sv =====
// Radial point remapper: 112-stage pipeline from point to remapped point.
// Depends on rpr_pkg (widths, stage map, exp2 table).
//
// Use: one 3D point word (point_x/y/z, signed Q16.16) enters per cycle on the
// in_ channel (valid/stall); one remapped word leaves on the out_ channel, or
// none when the point's distance from the origin reaches distance_cutoff.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata while
// no word is in flight; indexes above 5 are ignored.
// Throughput: one word per cycle while out_stall does not hold the pipeline;
// every stage holds one word, the 35-stage square root, 16 log2 squaring
// steps, 16 exp2 product steps and the 34-stage quotient run set the depth.
// Dropped points leave a bubble; surviving words keep their input order.
// Reset (rst_n low, synchronous) empties the pipeline and loads origin 0,
// exponent 1.0, scale 1.0 and cutoff 0xFFFFFFFF.
// When out_stall is high with a word waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module radial_point_remap_top
  import rpr_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [CW-1:0]      cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [CW-1:0] in_point_x,
  input  wire logic signed [CW-1:0] in_point_y,
  input  wire logic signed [CW-1:0] in_point_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [CW-1:0]    out_mapped_x,
  output logic signed [CW-1:0]    out_mapped_y,
  output logic signed [CW-1:0]    out_mapped_z
);

  // configuration
  logic signed [CW-1:0]  org_r [3];
  logic signed [EXW-1:0] expo_r;
  logic [CW-1:0]         scl_r;
  logic [CW-1:0]         cut_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      expo_r   <= 16'sd4096;
      scl_r    <= 32'd65536;
      cut_r    <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORIGIN_X: org_r[0] <= cfg_wdata;
        CFG_ORIGIN_Y: org_r[1] <= cfg_wdata;
        CFG_ORIGIN_Z: org_r[2] <= cfg_wdata;
        CFG_EXPONENT: expo_r   <= cfg_wdata[EXW-1:0];
        CFG_SCALE:    scl_r    <= cfg_wdata;
        CFG_CUTOFF:   cut_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline control: all stages move together
  logic vld_r [NST];
  logic adv;

  assign adv       = !vld_r[NST-1] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld_r[NST-1];

  logic signed [CW-1:0] pin [3];
  assign pin[0] = in_point_x;
  assign pin[1] = in_point_y;
  assign pin[2] = in_point_z;

  side_t sd_r [ST_DEND+1];

  // squares, their sum and the square root chain
  logic [SQW-1:0]  sq_r [3];
  logic [SUMW-1:0] sq_rem_r [LENW+1];
  logic [LENW-1:0] sq_len_r [LENW+1];

  // stage 0: offsets and magnitudes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [MAGW-1:0] d;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d = {pin[i][CW-1], pin[i]} - {org_r[i][CW-1], org_r[i]};
        sd_r[0].neg[i] <= d[MAGW-1];
        sd_r[0].mag[i] <= d[MAGW-1] ? MAGW'(-d) : MAGW'(d);
      end
    end
  end

  genvar g;
  generate
    for (g = 1; g < NST; g++) begin : g_vld
      if (g == ST_NORM) begin : g_drop
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_r[g] <= 1'b0;
          end else if (adv) begin
            vld_r[g] <= vld_r[g-1] && (sq_len_r[LENW] < {3'b0, cut_r});
          end
        end
      end else begin : g_pass
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_r[g] <= 1'b0;
          end else if (adv) begin
            vld_r[g] <= vld_r[g-1];
          end
        end
      end
    end
    for (g = 1; g <= ST_DEND; g++) begin : g_side
      always_ff @(posedge clk) begin
        if (adv) begin
          sd_r[g] <= sd_r[g-1];
        end
      end
    end
  endgenerate

  // stages 1-2: squares and their sum
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= sd_r[0].mag[i] * sd_r[0].mag[i];
      end
      sq_rem_r[0] <= SUMW'(sq_r[0]) + SUMW'(sq_r[1]) + SUMW'(sq_r[2]);
      sq_len_r[0] <= '0;
    end
  end

  // square root, one result bit per stage, top bit first
  generate
    for (g = 0; g < LENW; g++) begin : g_sqrt
      localparam int B = LENW - 1 - g;
      always_ff @(posedge clk) begin
        logic [SUMW-1:0] trial;
        trial = (SUMW'(sq_len_r[g]) << (B + 1)) + (SUMW'(1) << (2 * B));
        if (adv) begin
          if (sq_rem_r[g] >= trial) begin
            sq_rem_r[g+1] <= sq_rem_r[g] - trial;
            sq_len_r[g+1] <= sq_len_r[g] | (LENW'(1) << B);
          end else begin
            sq_rem_r[g+1] <= sq_rem_r[g];
            sq_len_r[g+1] <= sq_len_r[g];
          end
        end
      end
    end
  endgenerate

  // length and zero-length flag travel to the output
  logic [LENW-1:0] ln_r [ST_NORM:ST_DEND];
  logic            zl_r [ST_NORM:ST_DEND];

  generate
    for (g = ST_NORM + 1; g <= ST_DEND; g++) begin : g_len
      always_ff @(posedge clk) begin
        if (adv) begin
          ln_r[g] <= ln_r[g-1];
          zl_r[g] <= zl_r[g-1];
        end
      end
    end
  endgenerate

  // normalize: top bit index and Q1.30 mantissa
  logic [MW-1:0]  lm_r  [FRW+1];
  logic [FRW-1:0] lfr_r [FRW+1];
  logic [5:0]     lp_r  [FRW+1];

  always_ff @(posedge clk) begin
    logic [5:0]          p;
    logic [LENW+MW-2:0]  sh;
    p = '0;
    for (int b = 0; b < LENW; b++) begin
      if (sq_len_r[LENW][b]) p = 6'(b);
    end
    sh = {sq_len_r[LENW], 30'b0} >> p;
    if (adv) begin
      ln_r[ST_NORM] <= sq_len_r[LENW];
      zl_r[ST_NORM] <= (sq_len_r[LENW] == '0);
      lp_r[0]       <= p;
      lm_r[0]       <= sh[MW-1:0];
      lfr_r[0]      <= '0;
    end
  end

  // log2 fraction, one squaring per stage
  generate
    for (g = 0; g < FRW; g++) begin : g_log
      always_ff @(posedge clk) begin
        logic [2*MW-1:0] prod;
        logic [MW:0]     mm;
        prod = lm_r[g] * lm_r[g];
        mm   = prod[2*MW-1:MW-1];
        if (adv) begin
          lp_r[g+1] <= lp_r[g];
          if (mm[MW]) begin
            lm_r[g+1]  <= mm[MW:1];
            lfr_r[g+1] <= {lfr_r[g][FRW-2:0], 1'b1};
          end else begin
            lm_r[g+1]  <= mm[MW-1:0];
            lfr_r[g+1] <= {lfr_r[g][FRW-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  // y = floor(log2(L) * exponent / 2^12)
  logic [ACCW-1:0] ea_r  [FRW+1];
  logic [FRW-1:0]  eyf_r [FRW+1];
  logic signed [YIW-1:0] eyi_r [FRW+1];

  always_ff @(posedge clk) begin
    logic signed [7:0]  pm;
    logic signed [23:0] lg;
    logic signed [39:0] prod;
    pm   = 8'(lp_r[FRW]) - 8'(FRAC_BITS);
    lg   = {pm, lfr_r[FRW]};
    prod = lg * expo_r;
    if (adv) begin
      ea_r[0]  <= ACCW'(1) << 30;
      eyf_r[0] <= prod[12+FRW-1:12];
      eyi_r[0] <= prod[12+YW-1:12+FRW];
    end
  end

  // exp2 of the fraction, one table product per stage
  generate
    for (g = 0; g < FRW; g++) begin : g_exp
      always_ff @(posedge clk) begin
        logic [ACCW+MW-1:0] prod;
        prod = ea_r[g] * exp2_coef(4'(g));
        if (adv) begin
          eyf_r[g+1] <= eyf_r[g];
          eyi_r[g+1] <= eyi_r[g];
          ea_r[g+1]  <= eyf_r[g][FRW-1-g] ? prod[ACCW+29:30] : ea_r[g];
        end
      end
    end
  endgenerate

  // gain and numerators
  logic [BASEW-1:0]     base_r;
  logic signed [SHW-1:0] sh_r [ST_BASE:ST_SHF];
  logic [PPW-1:0]       pl_r [3];
  logic [PPW-1:0]       ph_r [3];
  logic [NUMW-1:0]      num_r [3];

  always_ff @(posedge clk) begin
    logic [NUMW:0] t;
    if (adv) begin
      base_r        <= scl_r * ea_r[FRW];
      sh_r[ST_BASE] <= SHW'(eyi_r[FRW]) - SHW'(30);
      sh_r[ST_PART] <= sh_r[ST_BASE];
      sh_r[ST_NUM]  <= sh_r[ST_PART];
      sh_r[ST_SHF]  <= sh_r[ST_NUM];
      for (int i = 0; i < 3; i++) begin
        pl_r[i]  <= base_r[31:0] * sd_r[ST_BASE].mag[i];
        ph_r[i]  <= base_r[63:32] * sd_r[ST_BASE].mag[i];
        t        = {32'b0, pl_r[i]} + {ph_r[i], 32'b0};
        num_r[i] <= t[NUMW-1:0];
      end
    end
  end

  // scale the numerator by 2^shift
  logic [XW-1:0] xw_r [3];
  logic          sb_r [3];

  always_ff @(posedge clk) begin
    logic signed [SHW-1:0] s;
    logic [6:0]            nsh;
    s   = sh_r[ST_NUM];
    nsh = 7'(-s);
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sb_r[i] <= (s > SHW'(SH_MAX)) && (|num_r[i]);
        if (s > SHW'(SH_MAX)) begin
          xw_r[i] <= '0;
        end else if (s >= 0) begin
          xw_r[i] <= {68'b0, num_r[i]} << s[6:0];
        end else if (s >= SHW'(SH_MIN)) begin
          xw_r[i] <= {68'b0, num_r[i] >> nsh};
        end else begin
          xw_r[i] <= '0;
        end
      end
    end
  end

  // saturation check, then restoring division by L
  logic [REMW-1:0] rem_r [QW+1][3];
  logic [QW-1:0]   q_r   [QW+1][3];
  logic            sat_r [ST_SAT:ST_DEND][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sat_r[ST_SAT][i] <= sb_r[i] || (|xw_r[i][XW-1:REMW])
                            || (xw_r[i][REMW-1:QW] >= ln_r[ST_SHF]);
        rem_r[0][i]      <= xw_r[i][REMW-1:0];
        q_r[0][i]        <= '0;
      end
    end
  end

  generate
    for (g = 0; g < QW; g++) begin : g_div
      localparam int B = QW - 1 - g;
      always_ff @(posedge clk) begin
        logic [REMW-1:0] dv;
        dv = REMW'(ln_r[ST_SAT+g]) << B;
        if (adv) begin
          for (int i = 0; i < 3; i++) begin
            sat_r[ST_SAT+g+1][i] <= sat_r[ST_SAT+g][i];
            if (rem_r[g][i] >= dv) begin
              rem_r[g+1][i] <= rem_r[g][i] - dv;
              q_r[g+1][i]   <= q_r[g][i] | (QW'(1) << B);
            end else begin
              rem_r[g+1][i] <= rem_r[g][i];
              q_r[g+1][i]   <= q_r[g][i];
            end
          end
        end
      end
    end
  endgenerate

  // origin +/- quotient, clamped
  logic signed [CW-1:0] mapped_r [3];

  always_ff @(posedge clk) begin
    logic signed [OVW-1:0] qv;
    logic signed [OVW-1:0] v;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        qv = {2'b0, q_r[QW][i]};
        v  = {{(OVW-CW){org_r[i][CW-1]}}, org_r[i]}
             + (sd_r[ST_DEND].neg[i] ? -qv : qv);
        if (zl_r[ST_DEND]) begin
          mapped_r[i] <= org_r[i];
        end else if (sat_r[ST_DEND][i]) begin
          mapped_r[i] <= sd_r[ST_DEND].neg[i] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
        end else if (v > $signed({5'b0, {31{1'b1}}})) begin
          mapped_r[i] <= {1'b0, {31{1'b1}}};
        end else if (v < $signed({5'b11111, 31'b0})) begin
          mapped_r[i] <= {1'b1, 31'b0};
        end else begin
          mapped_r[i] <= v[CW-1:0];
        end
      end
    end
  end

  assign out_mapped_x = mapped_r[0];
  assign out_mapped_y = mapped_r[1];
  assign out_mapped_z = mapped_r[2];

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for radial_point_remap_top: drives points, predicts
// remapped points with a bit-exact model, and checks each result word in order.
// Depends on rpr_pkg and radial_point_remap_top.
`timescale 1ns / 1ps
`default_nettype none
module tb
  import rpr_pkg::*;
();

  localparam int LAT = 112;

  typedef struct {
    logic signed [31:0] x, y, z;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_mapped_x, out_mapped_y, out_mapped_z;

  radial_point_remap_top dut (.*);

  // shadow registers
  logic signed [31:0] org_x, org_y, org_z;
  logic signed [15:0] pow_q12;
  logic [31:0] gain, cutoff;

  point_t mapped_q[$];
  int errors = 0;
  int idle_pct = 11;
  bit hold_out = 1'b0;

  initial forever #4 clk = ~clk;

  initial begin
    #2ms;
    $display("** radial_point_remap_top: FAILED **");
    $finish;
  end

  function automatic logic [34:0] isqrt(input logic [71:0] sum);
    logic [34:0] r;
    logic [34:0] c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (35'd1 << b);
      if ({37'd0, c} * {37'd0, c} <= sum) r = c;
    end
    return r;
  endfunction

  function automatic logic [30:0] tab(input int k);
    logic [30:0] t [16] = '{31'd1518500250, 31'd1276901417, 31'd1170923762,
      31'd1121280436, 31'd1097253708, 31'd1085434106, 31'd1079572136,
      31'd1076653033, 31'd1075196443, 31'd1074468888, 31'd1074105294,
      31'd1073923544, 31'd1073832680, 31'd1073787251, 31'd1073764537,
      31'd1073753181};
    return t[k];
  endfunction

  function automatic longint fshr(input longint v, input int k);
    if (v >= 0) return v >>> k;
    return -((-v + ((64'sd1 <<< k) - 1)) >>> k);
  endfunction

  // returns 0 when the point is dropped
  function automatic bit remap_point(input point_t p, output point_t r);
    longint d [3];
    longint o [3];
    logic [32:0] mag [3];
    logic [71:0] sum;
    logic [34:0] len;
    int top;
    logic [63:0] m, acc, frac, base, yf;
    longint lg, y, yi, s, v;
    logic [255:0] num, q;
    int nb;
    bit sat;
    o[0] = org_x; o[1] = org_y; o[2] = org_z;
    d[0] = longint'(p.x) - o[0];
    d[1] = longint'(p.y) - o[1];
    d[2] = longint'(p.z) - o[2];
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = d[i] < 0 ? -d[i] : d[i];
      sum += {39'd0, mag[i]} * {39'd0, mag[i]};
    end
    len = isqrt(sum);
    if (len >= {3'd0, cutoff}) return 0;
    if (len == 0) begin
      r.x = org_x; r.y = org_y; r.z = org_z;
      return 1;
    end
    top = 0;
    for (int b = 0; b < 35; b++) if (len[b]) top = b;
    m = top <= 30 ? {29'd0, len} << (30 - top) : {29'd0, len} >> (top - 30);
    frac = 0;
    for (int b = 0; b < 16; b++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= 64'd1 << 31) begin m >>= 1; frac |= 1; end
    end
    lg = longint'(top - 16) * 65536 + longint'(frac);
    y = fshr(lg * longint'(pow_q12), 12);
    yi = fshr(y, 16);
    yf = y - yi * 65536;
    acc = 64'd1 << 30;
    for (int b = 0; b < 16; b++)
      if (yf[15 - b]) acc = (acc * tab(b)) >> 30;
    base = {32'd0, gain} * acc;
    s = yi - 30;
    for (int i = 0; i < 3; i++) begin
      num = 256'(base) * 256'(mag[i]);
      q = '0;
      sat = 0;
      if (num != 0) begin
        nb = 0;
        for (int b = 0; b < 128; b++) if (num[b]) nb = b + 1;
        if (s >= 0) begin
          if (nb + s > 127) sat = 1;
          else q = (num << s) / 256'(len);
        end else begin
          q = num / 256'(len);
          q = (-s >= 128) ? '0 : q >> (-s);
        end
      end
      if (sat || q >= (256'd1 << 34)) v = d[i] < 0 ? -64'sd2147483648 : 64'sd2147483647;
      else begin
        v = o[i] + (d[i] < 0 ? -longint'(q[33:0]) : longint'(q[33:0]));
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
      end
      if (i == 0) r.x = v[31:0];
      else if (i == 1) r.y = v[31:0];
      else r.z = v[31:0];
    end
    return 1;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    point_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (mapped_q.size() == 0) report("unexpected word", out_mapped_x, 0);
      else begin
        w = mapped_q.pop_front();
        if (out_mapped_x !== w.x) report("mapped_x", out_mapped_x, w.x);
        if (out_mapped_y !== w.y) report("mapped_y", out_mapped_y, w.y);
        if (out_mapped_z !== w.z) report("mapped_z", out_mapped_z, w.z);
      end
    end
  end

  always @(negedge clk)
    out_stall <= hold_out || ($urandom_range(99) < idle_pct);

  // registers change only with the pipeline empty
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ORIGIN_X: org_x = val;
      CFG_ORIGIN_Y: org_y = val;
      CFG_ORIGIN_Z: org_z = val;
      CFG_EXPONENT: pow_q12 = val[15:0];
      CFG_SCALE:    gain = val;
      CFG_CUTOFF:   cutoff = val;
      default: ;
    endcase
  endtask

  task automatic send_point(input point_t p);
    point_t r;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= p.x; in_point_y <= p.y; in_point_z <= p.z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (remap_point(p, r)) mapped_q.insert(mapped_q.size(), r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (mapped_q.size() != 0) @(posedge clk);
    repeat (LAT + 8) @(posedge clk);
  endtask

  function automatic point_t mk(input logic [31:0] x, y, z);
    point_t p;
    p.x = x; p.y = y; p.z = z;
    return p;
  endfunction

  // point near origin scaled by a random shift so sizes vary widely
  function automatic logic [31:0] near(input logic [31:0] o);
    logic [31:0] d;
    d = $urandom >>> $urandom_range(31);
    return ($urandom_range(1)) ? o + d : o - d;
  endfunction

  task automatic test_directed();
    send_point(mk(0, 0, 0));                                  // zero length
    send_point(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff)); // extremes
    send_point(mk(32'h80000000, 32'h80000000, 32'h80000000));
    send_point(mk(32'h00010000, 0, 0));                       // unit length
    send_point(mk(32'hffff0000, 32'h00020000, 32'h00030000));
    send_point(mk(1, 0, 0));                                  // tiny length
    send_point(mk(32'hffffffff, 32'hffffffff, 1));
    send_point(mk(32'h12345678, 32'hedcba987, 32'h0));        // one zero axis
    drain();
  endtask

  task automatic test_cutoff();
    write_reg(CFG_CUTOFF, 32'd0);                             // all dropped
    repeat (5) send_point(mk($urandom, $urandom, $urandom));
    send_point(mk(0, 0, 0));
    write_reg(CFG_CUTOFF, 32'h00030000);
    send_point(mk(32'h00030000, 0, 0));                       // exactly at cutoff
    send_point(mk(32'h0002ffff, 0, 0));
    send_point(mk(32'h00020000, 32'h00020000, 32'h00010000)); // L = 3
    drain();
    write_reg(CFG_CUTOFF, 32'hffffffff);
  endtask

  task automatic test_gain();
    // huge gain and negative / extreme exponents
    write_reg(CFG_SCALE, 32'hffffffff);
    write_reg(CFG_EXPONENT, 16'h7fff);
    send_point(mk(32'h00100000, 32'hfff00000, 0));
    send_point(mk(32'h7fffffff, 1, 0));
    write_reg(CFG_EXPONENT, 16'h8000);
    send_point(mk(1, 0, 0));
    send_point(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    write_reg(CFG_SCALE, 32'd0);
    send_point(mk(32'h00050000, 32'h00010000, 0));
    write_reg(CFG_EXPONENT, 16'd0);
    write_reg(CFG_SCALE, 32'h00010000);
    send_point(mk(32'h00050000, 32'hfffe0000, 32'h00000123));
    drain();
  endtask

  task automatic run_random(input int n);
    point_t p;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) p = mk($urandom, $urandom, $urandom);
      else p = mk(near(org_x), near(org_y), near(org_z));
      send_point(p);
    end
    drain();
  endtask

  task automatic set_random_config();
    write_reg(CFG_ORIGIN_X, $urandom_range(1) ? $urandom : 32'd0);
    write_reg(CFG_ORIGIN_Y, $urandom >>> $urandom_range(31));
    write_reg(CFG_ORIGIN_Z, $urandom_range(1) ? 32'h80000000 : $urandom);
    write_reg(CFG_EXPONENT, $urandom_range(1) ? 32'($urandom_range(8192)) : $urandom);
    write_reg(CFG_SCALE, $urandom >> $urandom_range(31));
    write_reg(CFG_CUTOFF, $urandom_range(2) ? 32'hffffffff : $urandom);
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 4; ph++) begin
      set_random_config();
      run_random(80);
    end
    write_reg(CFG_ORIGIN_X, 32'h7fffffff);
    write_reg(CFG_ORIGIN_Y, 32'h80000000);
    write_reg(CFG_ORIGIN_Z, 32'h0);
    write_reg(CFG_EXPONENT, 16'h1000);
    write_reg(CFG_SCALE, 32'h00010000);
    write_reg(CFG_CUTOFF, 32'hffffffff);
    run_random(60);
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    run_random(80);
    idle_pct = 11;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_out = 1'b1;
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
      end
      run_random(150);
    join
  endtask

  initial begin
    org_x = 0; org_y = 0; org_z = 0;
    pow_q12 = 16'd4096; gain = 32'h00010000; cutoff = 32'hffffffff;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_cutoff();
    test_gain();
    test_random();
    test_no_idle();
    test_backpressure();
    if (errors == 0) $display("** radial_point_remap_top: PASSED **");
    else $display("** radial_point_remap_top: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
sv/rpr_pkg.sv
sv/radial_point_remap_top.sv
tb/tb.sv
